// ===== rtl/ncs_pkg.sv =====
package ncs_pkg;

   localparam int HISTORY_DEPTH_DEF  = 8192;
   localparam int TEMPLATE_DEPTH_DEF = 2048;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 13;
   localparam int POS_W      = 13;
   localparam int OVERLAP_W  = 12;
   localparam int RANGE_W    = 11;
   localparam int FRAME_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int SEARCH_STEP = 4;

   localparam logic [OVERLAP_W-1:0] OVERLAP_RST = 12'd512;
   localparam logic [RANGE_W-1:0]   RANGE_RST   = 11'd512;
   localparam logic [FRAME_W-1:0]   FRAME_RST   = 12'd1024;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TMPL = 2'd0,
      ACT_HIST = 2'd1,
      ACT_SRCH = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OVERLAP = 2'd0,
      REG_RANGE   = 2'd1,
      REG_FRAME   = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      MAC_HOLD,
      MAC_CLR,
      MAC_AB,
      MAC_AA,
      MAC_BB
   } mac_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_POS,
      ST_RD,
      ST_MAB,
      ST_MAA,
      ST_MBB,
      ST_EVAL,
      ST_SQ0,
      ST_SQ1,
      ST_MA0,
      ST_MA1,
      ST_MB0,
      ST_MB1,
      ST_DECIDE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/ncs_req_if.sv =====
interface ncs_req_if #(
   parameter int SAMPLE_BITS = ncs_pkg::SAMPLE_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [ncs_pkg::ACTION_W-1:0]        action;
   logic [ncs_pkg::INDEX_W-1:0]         index;
   logic signed [SAMPLE_BITS-1:0]       sample;
   logic [ncs_pkg::INDEX_W-1:0]         target_pos;

   modport source (output valid, action, index, sample, target_pos, input ready);
   modport sink   (input valid, action, index, sample, target_pos, output ready);
endinterface

// ===== rtl/ncs_rsp_if.sv =====
interface ncs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ncs_pkg::POS_W-1:0]    best_pos;
   logic                         scanned_any;

   modport source (output valid, best_pos, scanned_any, input ready);
   modport sink   (input valid, best_pos, scanned_any, output ready);
endinterface

// ===== rtl/ncs_mac.sv =====
module ncs_mac #(
   parameter int SAMPLE_BITS = ncs_pkg::SAMPLE_BITS_DEF,
   parameter int CW          = 2 * ncs_pkg::SAMPLE_BITS_DEF + 11,
   parameter int EW          = 2 * ncs_pkg::SAMPLE_BITS_DEF + 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ncs_pkg::mac_op_type           op,
   input  logic signed [SAMPLE_BITS-1:0] a,
   input  logic signed [SAMPLE_BITS-1:0] b,
   output logic signed [CW-1:0]          c,
   output logic [EW-1:0]                 e1,
   output logic [EW-1:0]                 e2
);
   import ncs_pkg::*;

   logic signed [SAMPLE_BITS-1:0]   opx, opy;
   logic signed [2*SAMPLE_BITS-1:0] prod;
   logic signed [CW-1:0]            c_ff, c_in;
   logic [EW-1:0]                   e1_ff, e1_in, e2_ff, e2_in;

   // single multiplier, operand pair picked by phase
   always_comb begin
      opx = a;
      opy = b;
      unique case (op)
         MAC_AA: begin
            opx = a;
            opy = a;
         end
         MAC_BB: begin
            opx = b;
            opy = b;
         end
         default: begin
            opx = a;
            opy = b;
         end
      endcase
      prod  = opx * opy;
      c_in  = c_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      unique case (op)
         MAC_CLR: begin
            c_in  = '0;
            e1_in = '0;
            e2_in = '0;
         end
         MAC_AB:  c_in  = c_ff + CW'(prod);
         MAC_AA:  e1_in = e1_ff + EW'(unsigned'(prod));
         MAC_BB:  e2_in = e2_ff + EW'(unsigned'(prod));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff  <= '0;
         e1_ff <= '0;
         e2_ff <= '0;
      end else begin
         c_ff  <= c_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
   end

   assign c  = c_ff;
   assign e1 = e1_ff;
   assign e2 = e2_ff;
endmodule

// ===== rtl/ncs_sermul.sv =====
module ncs_sermul #(
   parameter int XW = 84,
   parameter int YW = 42
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [XW-1:0]      x,
   input  logic [YW-1:0]      y,
   output logic               done,
   output logic [XW+YW-1:0]   prod
);
   localparam int PW = XW + YW;
   localparam int NW = $clog2(YW + 1);

   logic [PW-1:0] x_ff, x_in, acc_ff, acc_in;
   logic [YW-1:0] y_ff, y_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = PW'(x);
         y_in    = y;
         acc_in  = '0;
         cnt_in  = NW'(YW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = acc_ff + x_ff;
         end
         x_in   = x_ff << 1;
         y_in   = y_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ===== rtl/normalized_xcorr_best_lag_search_top.sv =====
// Channel   Dir  Payload                                  Handshake
// req_chan  in   action, index, sample, target_pos       valid/ready
// rsp_chan  out  best_pos, scanned_any                   valid/ready
// csr_*     in   csr_index selects register, csr_wdata    csr_we, no wait
//
// Loads (template/history) are written as accepted and may come back to back. A search
// runs a setup state, then per candidate a MAC pass over overlap_size samples on the
// single MAC multiplier (3 uses per sample) and three products on the bit-serial
// compare multiplier, then the closing states. Nothing is accepted while a
// search runs. A finished result waits in the output register; loads are
// taken meanwhile, and a stalled result holds the block in its closing state.
// Reset is synchronous and clears control state only; stores are not cleared.
module normalized_xcorr_best_lag_search_top #(
   parameter int HISTORY_DEPTH  = ncs_pkg::HISTORY_DEPTH_DEF,
   parameter int TEMPLATE_DEPTH = ncs_pkg::TEMPLATE_DEPTH_DEF,
   parameter int SAMPLE_BITS    = ncs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ncs_req_if.sink                           req_chan,
   ncs_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [ncs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ncs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ncs_pkg::*;

   localparam int HAW = $clog2(HISTORY_DEPTH);
   localparam int TAW = $clog2(TEMPLATE_DEPTH);
   localparam int PW  = ($clog2(HISTORY_DEPTH + 1) > 14) ? $clog2(HISTORY_DEPTH + 1) : 14;
   localparam int CW  = 2 * SAMPLE_BITS + 11;
   localparam int EW  = 2 * SAMPLE_BITS + 10;

   logic [OVERLAP_W-1:0] overlap_ff;
   logic [RANGE_W-1:0]   range_ff;
   logic [FRAME_W-1:0]   frame_ff;

   logic signed [SAMPLE_BITS-1:0] tmem [TEMPLATE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] hmem [HISTORY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] trd_ff, hrd_ff;

   state_type state_ff, state_in;
   logic [INDEX_W-1:0]   target_ff, target_in;
   logic [PW-1:0]        pos_ff, pos_in, end_ff, end_in;
   logic [OVERLAP_W-1:0] i_ff, i_in;
   logic [TAW-1:0]       ti_ff, ti_in;
   logic [HAW-1:0]       hp_ff, hp_in;
   logic                 have_ff, have_in, any_ff, any_in;
   logic [POS_W-1:0]     best_pos_ff, best_pos_in;
   logic                 best_neg_ff, best_neg_in, best_zero_ff, best_zero_in;
   logic [EW-1:0]        best_e_ff, best_e_in;
   logic [2*EW-1:0]      best_csq_ff, best_csq_in, csq_ff, csq_in;
   logic signed [CW-1:0] c_fix_ff, c_fix_in;
   logic [EW-1:0]        e2_fix_ff, e2_fix_in;
   logic [3*EW-1:0]      pa_ff, pa_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_any_ff, rsp_any_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;

   mac_op_type           mac_op;
   logic signed [CW-1:0] mac_c;
   logic [EW-1:0]        mac_e1, mac_e2, mag_c;
   logic                 mul_start, mul_done;
   logic [2*EW-1:0]      mul_x;
   logic [EW-1:0]        mul_y;
   logic [3*EW-1:0]      mul_prod;

   logic                 req_fire, zero_e, c_neg, c_zero, take;
   logic [1:0]           rank_new, rank_best;
   logic [PW-1:0]        start_w, sum_w, lim_w, hd_w;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign hd_w = PW'(HISTORY_DEPTH);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_ff <= OVERLAP_RST;
         range_ff   <= RANGE_RST;
         frame_ff   <= FRAME_RST;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_OVERLAP: overlap_ff <= csr_wdata;
            REG_RANGE:   range_ff   <= csr_wdata[RANGE_W-1:0];
            REG_FRAME:   frame_ff   <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // sample stores
   always_ff @(posedge clock) begin
      if (req_fire && action_type'(req_chan.action) == ACT_TMPL
          && 32'(req_chan.index) < TEMPLATE_DEPTH) begin
         tmem[TAW'(req_chan.index)] <= req_chan.sample;
      end
      trd_ff <= tmem[ti_ff];
   end

   always_ff @(posedge clock) begin
      if (req_fire && action_type'(req_chan.action) == ACT_HIST
          && 32'(req_chan.index) < HISTORY_DEPTH) begin
         hmem[HAW'(req_chan.index)] <= req_chan.sample;
      end
      hrd_ff <= hmem[hp_ff];
   end

   ncs_mac #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CW(CW),
      .EW(EW)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .op(mac_op),
      .a(trd_ff),
      .b(hrd_ff),
      .c(mac_c),
      .e1(mac_e1),
      .e2(mac_e2)
   );

   ncs_sermul #(
      .XW(2 * EW),
      .YW(EW)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .x(mul_x),
      .y(mul_y),
      .done(mul_done),
      .prod(mul_prod)
   );

   always_comb begin
      start_w = (PW'(target_ff) > PW'(range_ff)) ? PW'(target_ff) - PW'(range_ff) : '0;
      sum_w   = PW'(target_ff) + PW'(range_ff);
      lim_w   = (PW'(frame_ff) < hd_w) ? hd_w - PW'(frame_ff) : '0;
      zero_e  = (mac_e1 == '0) || (mac_e2 == '0);
      c_neg   = c_fix_ff < 0;
      c_zero  = c_fix_ff == '0;
      mag_c   = c_neg ? EW'(-c_fix_ff) : EW'(c_fix_ff);
      rank_new  = c_neg ? 2'd0 : (c_zero ? 2'd1 : 2'd2);
      rank_best = best_neg_ff ? 2'd0 : (best_zero_ff ? 2'd1 : 2'd2);
      // exact ratio compare: c^2*best_e against best_c^2*e
      priority if (!have_ff) begin
         take = 1'b1;
      end else if (rank_new != rank_best) begin
         take = rank_new > rank_best;
      end else if (c_zero) begin
         take = 1'b0;
      end else if (c_neg) begin
         take = pa_ff < mul_prod;
      end else begin
         take = pa_ff > mul_prod;
      end
   end

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      i_in         = i_ff;
      ti_in        = ti_ff;
      hp_in        = hp_ff;
      have_in      = have_ff;
      any_in       = any_ff;
      best_pos_in  = best_pos_ff;
      best_neg_in  = best_neg_ff;
      best_zero_in = best_zero_ff;
      best_e_in    = best_e_ff;
      best_csq_in  = best_csq_ff;
      csq_in       = csq_ff;
      c_fix_in     = c_fix_ff;
      e2_fix_in    = e2_fix_ff;
      pa_in        = pa_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_any_in   = rsp_any_ff;
      mac_op       = MAC_HOLD;
      mul_start    = 1'b0;
      mul_x        = {EW'(0), mag_c};
      mul_y        = mag_c;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && action_type'(req_chan.action) == ACT_SRCH) begin
               target_in = req_chan.target_pos;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            pos_in      = start_w;
            end_in      = (lim_w < sum_w) ? lim_w : sum_w;
            have_in     = 1'b0;
            any_in      = 1'b0;
            best_pos_in = target_ff;
            state_in    = ST_POS;
         end
         ST_POS: begin
            if (pos_ff < end_ff) begin
               any_in   = 1'b1;
               i_in     = '0;
               ti_in    = '0;
               hp_in    = HAW'(pos_ff);
               mac_op   = MAC_CLR;
               state_in = (overlap_ff == '0) ? ST_EVAL : ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD:  state_in = ST_MAB;
         ST_MAB: begin
            mac_op   = MAC_AB;
            state_in = ST_MAA;
         end
         ST_MAA: begin
            mac_op   = MAC_AA;
            state_in = ST_MBB;
         end
         ST_MBB: begin
            mac_op = MAC_BB;
            i_in   = i_ff + 1'b1;
            ti_in  = (32'(ti_ff) == TEMPLATE_DEPTH - 1) ? '0 : ti_ff + 1'b1;
            hp_in  = (32'(hp_ff) == HISTORY_DEPTH - 1) ? '0 : hp_ff + 1'b1;
            state_in = ({1'b0, i_ff} + 1'b1 == {1'b0, overlap_ff}) ? ST_EVAL : ST_RD;
         end
         ST_EVAL: begin
            c_fix_in  = zero_e ? '0 : mac_c;
            e2_fix_in = zero_e ? EW'(1) : mac_e2;
            state_in  = ST_SQ0;
         end
         ST_SQ0: begin
            mul_start = 1'b1;
            state_in  = ST_SQ1;
         end
         ST_SQ1: begin
            if (mul_done) begin
               csq_in   = mul_prod[2*EW-1:0];
               state_in = ST_MA0;
            end
         end
         ST_MA0: begin
            mul_start = 1'b1;
            mul_x     = csq_ff;
            mul_y     = best_e_ff;
            state_in  = ST_MA1;
         end
         ST_MA1: begin
            if (mul_done) begin
               pa_in    = mul_prod;
               state_in = ST_MB0;
            end
         end
         ST_MB0: begin
            mul_start = 1'b1;
            mul_x     = best_csq_ff;
            mul_y     = e2_fix_ff;
            state_in  = ST_MB1;
         end
         ST_MB1: begin
            if (mul_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (take) begin
               have_in      = 1'b1;
               best_pos_in  = pos_ff[POS_W-1:0];
               best_neg_in  = c_neg;
               best_zero_in = c_zero;
               best_e_in    = e2_fix_ff;
               best_csq_in  = csq_ff;
            end
            pos_in   = pos_ff + PW'(SEARCH_STEP);
            state_in = ST_POS;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = best_pos_ff;
               rsp_any_in   = any_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      i_ff         <= i_in;
      ti_ff        <= ti_in;
      hp_ff        <= hp_in;
      have_ff      <= have_in;
      any_ff       <= any_in;
      best_pos_ff  <= best_pos_in;
      best_neg_ff  <= best_neg_in;
      best_zero_ff <= best_zero_in;
      best_e_ff    <= best_e_in;
      best_csq_ff  <= best_csq_in;
      csq_ff       <= csq_in;
      c_fix_ff     <= c_fix_in;
      e2_fix_ff    <= e2_fix_in;
      pa_ff        <= pa_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_any_ff   <= rsp_any_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.best_pos    = rsp_pos_ff;
   assign rsp_chan.scanned_any = rsp_any_ff;
endmodule

// ===== rtl/ncs_checker.sv =====
module ncs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [ncs_pkg::ACTION_W-1:0]    req_action,
   input logic                            rsp_valid,
   input logic                            rsp_ready
);
   import ncs_pkg::*;

   logic req_fire, is_search;
   assign req_fire  = req_valid && req_ready;
   assign is_search = action_type'(req_action) == ACT_SRCH;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_search |=> !req_ready)
      else $error("ready stayed high after search transaction");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_search && !rsp_valid |=> !rsp_valid)
      else $error("response produced by a load transaction");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind normalized_xcorr_best_lag_search_top ncs_checker u_ncs_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_action(req_chan.action),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready)
);

// ===== sim/testbench.sv =====
module testbench;
   import ncs_pkg::*;

   localparam int HIST_N = 8192;
   localparam int TMPL_N = 2048;
   localparam int TMPL_FILL = 64;
   localparam int HIST_FILL = 320;
   localparam int STALL_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 50;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             any;
   } lag_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ncs_req_if req ();
   ncs_rsp_if rsp ();

   normalized_xcorr_best_lag_search_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block state
   logic signed [15:0] tmpl_mem [TMPL_N];
   logic signed [15:0] hist_mem [HIST_N];
   int unsigned ovl_len = OVERLAP_RST;
   int unsigned win_half = RANGE_RST;
   int unsigned frm_len = FRAME_RST;

   lag_result_type pending_lags[$];
   int fails = 0;
   int src_idle = 0;
   int snk_idle = 0;
   int stall_cnt = 0;

   initial begin
      req.valid = 1'b0;
      req.action = ACT_NONE;
      req.index = '0;
      req.sample = '0;
      req.target_pos = '0;
      rsp.ready = 1'b0;
   end

   // exact similarity order: ca/sqrt(ea) > cb/sqrt(eb)
   function automatic bit more_similar(longint ca, longint unsigned ea,
                                       longint cb, longint unsigned eb);
      int sa, sb;
      logic [191:0] ma, mb, x, y;
      sa = ca > 0 ? 1 : (ca < 0 ? -1 : 0);
      sb = cb > 0 ? 1 : (cb < 0 ? -1 : 0);
      if (sa != sb) return sa > sb;
      if (sa == 0) return 1'b0;
      ma = ca < 0 ? 192'(-ca) : 192'(ca);
      mb = cb < 0 ? 192'(-cb) : 192'(cb);
      x = ma * ma * 192'(eb);
      y = mb * mb * 192'(ea);
      return sa > 0 ? (x > y) : (x < y);
   endfunction

   function automatic lag_result_type predict_best_lag(logic [POS_W-1:0] tgt);
      int unsigned st, en, lim, p, i;
      longint a, b, c, best_c;
      longint unsigned e1, e2, best_e;
      bit have;
      lag_result_type r;
      st = tgt > win_half ? tgt - win_half : 0;
      en = tgt + win_half;
      lim = frm_len < HIST_N ? HIST_N - frm_len : 0;
      if (lim < en) en = lim;
      r.pos = tgt;
      r.any = 1'b0;
      have = 1'b0;
      best_c = 0;
      best_e = 1;
      for (p = st; p < en; p += SEARCH_STEP) begin
         c = 0;
         e1 = 0;
         e2 = 0;
         for (i = 0; i < ovl_len; i++) begin
            a = tmpl_mem[i % TMPL_N];
            b = hist_mem[(p + i) % HIST_N];
            c += a * b;
            e1 += a * a;
            e2 += b * b;
         end
         if (e1 == 0 || e2 == 0) begin
            c = 0;
            e2 = 1;
         end
         r.any = 1'b1;
         if (!have || more_similar(c, e2, best_c, best_e)) begin
            have = 1'b1;
            best_c = c;
            best_e = e2;
            r.pos = p[POS_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic send_item(action_type act, logic [INDEX_W-1:0] idx,
                            logic [15:0] smp, logic [INDEX_W-1:0] tgt);
      if ($urandom_range(99) < src_idle) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.index <= idx;
      req.sample <= smp;
      req.target_pos <= tgt;
      do @(posedge clock); while (!req.ready);
      case (act)
         ACT_TMPL: if (idx < TMPL_N) tmpl_mem[idx] = smp;
         ACT_HIST: hist_mem[idx] = smp;
         ACT_SRCH: pending_lags.push_back(predict_best_lag(tgt));
         default: ;
      endcase
   endtask

   // wait for every result, then let a trailing transaction settle
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_lags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type r, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (r)
         REG_OVERLAP: ovl_len = v;
         REG_RANGE:   win_half = v[RANGE_W-1:0];
         REG_FRAME:   frm_len = v;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned ovl, int unsigned rng, int unsigned frm);
      drain();
      write_reg(REG_OVERLAP, ovl);
      write_reg(REG_RANGE, rng);
      write_reg(REG_FRAME, frm);
   endtask

   // searches only ever read the filled regions
   task automatic test_fill_stores();
      for (int i = 0; i < TMPL_FILL; i++) send_item(ACT_TMPL, i, $urandom, 0);
      for (int i = 0; i < HIST_FILL; i++) send_item(ACT_HIST, i, $urandom, 0);
   endtask

   task automatic test_directed();
      set_regs(8, 16, 1024);
      send_item(ACT_TMPL, 0, 16'sh8000, 0);
      send_item(ACT_TMPL, 1, 16'sh7fff, 0);
      send_item(ACT_TMPL, 13'h1fff, 16'h1234, 0);   // out of range, ignored
      send_item(ACT_HIST, 13'h1fff, 16'sh7fff, 0);
      send_item(ACT_NONE, 13'h0aaa, 16'h5555, 13'h1555);
      send_item(ACT_SRCH, 0, 0, 100);
      send_item(ACT_SRCH, 0, 0, 0);
      send_item(ACT_SRCH, 0, 0, 13'h1fff);   // window empty
      // window end clipped by the frame limit
      for (int i = 7144; i < 7172; i++) send_item(ACT_HIST, i, $urandom, 0);
      send_item(ACT_SRCH, 0, 0, 7160);
      // zero history energy
      for (int i = 224; i < 264; i++) send_item(ACT_HIST, i, 0, 0);
      send_item(ACT_SRCH, 0, 0, 240);
      // zero template energy, then restore
      for (int i = 0; i < 8; i++) send_item(ACT_TMPL, i, 0, 0);
      send_item(ACT_SRCH, 0, 0, 150);
      for (int i = 0; i < 8; i++) send_item(ACT_TMPL, i, $urandom, 0);
      set_regs(0, 0, 512);
      send_item(ACT_SRCH, 0, 0, 300);
      set_regs(0, 12, 2048);
      send_item(ACT_SRCH, 0, 0, 6140);
      set_regs(60, 8, 1024);
      send_item(ACT_SRCH, 0, 0, 200);
      set_regs(12, 2, 4095);
      send_item(ACT_SRCH, 0, 0, 60);
      set_regs(1, 300, 4095);
      send_item(ACT_SRCH, 0, 0, 0);
      drain();
      write_reg(REG_NONE, 12'hfff);
   endtask

   // plant a scaled template copy near a target, then search around it
   task automatic planted_search();
      int unsigned p, sh;
      bit neg;
      logic signed [15:0] v;
      p = $urandom_range(0, HIST_FILL - 64);
      sh = $urandom_range(0, 4);
      neg = $urandom_range(1);
      for (int i = 0; i < ovl_len; i++) begin
         v = tmpl_mem[i % TMPL_N] >>> (sh + neg);
         send_item(ACT_HIST, (p + i) % HIST_N, neg ? -v : v, 0);
      end
      send_item(ACT_SRCH, 0, 0, p + $urandom_range(0, 8) - 4);
   endtask

   task automatic test_random(int n);
      int unsigned lim;
      int cnt;
      lim = HIST_N - frm_len;
      cnt = 0;
      while (cnt < n) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
               planted_search();
               cnt += ovl_len + 1;
            end
            8, 9, 10: begin
               send_item(ACT_SRCH, $urandom, $urandom, $urandom_range(0, HIST_FILL - 40));
               cnt++;
            end
            11: begin
               // target past the frame limit: empty window
               send_item(ACT_SRCH, $urandom, $urandom, $urandom_range(lim + 24, HIST_N - 1));
               cnt++;
            end
            12, 13, 14: begin
               send_item(ACT_TMPL, $urandom, $urandom, $urandom);
               cnt++;
            end
            15: begin
               send_item(ACT_NONE, $urandom, $urandom, $urandom);
               cnt++;
            end
            default: begin
               send_item(ACT_HIST, $urandom, $urandom, $urandom);
               cnt++;
            end
         endcase
      end
   endtask

   task automatic test_random_phases();
      src_idle = 10;
      snk_idle = 57;
      set_regs($urandom_range(1, 12), $urandom_range(0, 24), $urandom_range(512, 2048));
      test_random(450);
      src_idle = 57;
      snk_idle = 10;
      set_regs($urandom_range(1, 12), $urandom_range(0, 24), $urandom_range(512, 2048));
      test_random(450);
      src_idle = 0;
      snk_idle = 0;
      set_regs($urandom_range(1, 12), $urandom_range(0, 24), $urandom_range(512, 2048));
      test_random(450);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      lag_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_lags.size() == 0) begin
            $error("unexpected transaction: best_pos %0d scanned_any %0d",
                   rsp.best_pos, rsp.scanned_any);
            fails++;
         end else begin
            exp_r = pending_lags.pop_front();
            if (rsp.best_pos !== exp_r.pos) begin
               $error("best_pos expected %0d actual %0d", exp_r.pos, rsp.best_pos);
               fails++;
            end
            if (rsp.scanned_any !== exp_r.any) begin
               $error("scanned_any expected %0d actual %0d", exp_r.any, rsp.scanned_any);
               fails++;
            end
         end
      end
      rsp.ready <= !reset && ($urandom_range(99) >= snk_idle);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we)
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_stores();
      test_directed();
      test_random_phases();
      drain();
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
